FILE: sv/block_weighted_color_distance_macros.svh
// Assertion macros for the weighted color distance block.
// No dependencies; included by the checker module.
`ifndef BLOCK_WEIGHTED_COLOR_DISTANCE_MACROS_SVH
`define BLOCK_WEIGHTED_COLOR_DISTANCE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WCD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("weighted color distance check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WCD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("weighted color distance check failed");

`endif

FILE: sv/wcd_pkg.sv
// Shared widths, constants, state and command types of the weighted color distance block.
// No dependencies.
`timescale 1ns / 1ps

package wcd_pkg;

	localparam int CH_W        = 16;
	localparam int SUMRED_W    = 17;
	localparam int SQ_W        = 32;
	localparam int OPA_W       = 19;
	localparam int PROD_W      = OPA_W + SQ_W;
	localparam int NUM_W       = 54;
	localparam int FRAC_SHIFT  = 17;
	localparam int PAIR_W      = NUM_W - FRAC_SHIFT;
	localparam int SUM_W       = 40;
	localparam int AVG_SHIFT   = 4;
	localparam int OUT_W       = SUM_W - AVG_SHIFT;
	localparam int GREEN_SHIFT = 19;
	localparam int BLOCK_PAIRS = 16;
	localparam int CNT_W       = 4;

	// Red and blue weights scaled by 2^17: (2 + r) and (3 - r).
	localparam logic [OPA_W-1:0] RED_BIAS  = OPA_W'(262144);
	localparam logic [OPA_W-1:0] BLUE_BIAS = OPA_W'(393216);
	localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(BLOCK_PAIRS - 1);
	localparam logic [OUT_W-1:0] OUT_MAX   = OUT_W'(64'd38654705664);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_SQR,
		ST_SQG,
		ST_SQB,
		ST_WR,
		ST_WB,
		ST_ACC,
		ST_SUM
	} st_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIFF,
		OP_SQR,
		OP_SQG,
		OP_SQB,
		OP_WR,
		OP_WB,
		OP_ACC,
		OP_SUM
	} op_t;

	typedef struct packed {
		op_t op;
	} wcd_cmd_t;

	typedef struct packed {
		logic last_pair;
		logic out_busy;
	} wcd_status_t;

endpackage

FILE: sv/block_weighted_color_distance.sv
// Top level of the block-averaged red-mean weighted RGB distance unit.
// Depends on wcd_pkg, wcd_ctrl and wcd_datapath.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+-----------------------------------------------
//   in      | in_valid / in_ready  | a_red a_green a_blue b_red b_green b_blue (16b)
//   out     | out_valid / out_ready| block_distance (36b), one per 16 pairs
//
// Each pair passes through the sequencer steps in order: the transfer, the
// differences and the red sum, the three squares and the red and blue
// weightings on the single shared multiplier, the addition of the weighted
// products and the fold of the pair into the running sum; only then is a new pair taken.
// Reset (arst_n low) clears the running sum, the pair count and the output valid.
// A stalled output only delays the sixteenth pair of the following block, which
// waits in its final step until the previous result has been taken.
`timescale 1ns / 1ps

module block_weighted_color_distance
	import wcd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [CH_W-1:0]  a_red,
	input  logic [CH_W-1:0]  a_green,
	input  logic [CH_W-1:0]  a_blue,
	input  logic [CH_W-1:0]  b_red,
	input  logic [CH_W-1:0]  b_green,
	input  logic [CH_W-1:0]  b_blue,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OUT_W-1:0] block_distance
);

	// Commands flow from the sequencer to the datapath; status flows back.
	wcd_cmd_t    cmd;
	wcd_status_t status;

	// The sequencer walks one pair through its steps and only offers in_ready
	// when it is idle, so at most one pair is in flight.
	wcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath holds the captured pair, the squared differences, the
	// numerator of the pair distance, the 40-bit block sum and the output
	// register. The pair distance is the numerator scaled down by 2^17 with
	// truncation, and the block average is the sum shifted right by four.
	wcd_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.a_red          (a_red),
		.a_green        (a_green),
		.a_blue         (a_blue),
		.b_red          (b_red),
		.b_green        (b_green),
		.b_blue         (b_blue),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.block_distance (block_distance)
	);

endmodule

FILE: sv/wcd_ctrl.sv
// Sequencer of the weighted color distance block: steps one pair through the datapath.
// Depends on wcd_pkg.
`timescale 1ns / 1ps

module wcd_ctrl
	import wcd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  wcd_status_t status,
	output wcd_cmd_t    cmd
);

	st_t state_q;
	st_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_DIFF;
				end
			end
			ST_DIFF: begin
				cmd.op  = OP_DIFF;
				state_d = ST_SQR;
			end
			ST_SQR: begin
				cmd.op  = OP_SQR;
				state_d = ST_SQG;
			end
			ST_SQG: begin
				cmd.op  = OP_SQG;
				state_d = ST_SQB;
			end
			ST_SQB: begin
				cmd.op  = OP_SQB;
				state_d = ST_WR;
			end
			ST_WR: begin
				cmd.op  = OP_WR;
				state_d = ST_WB;
			end
			ST_WB: begin
				cmd.op  = OP_WB;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.op  = OP_ACC;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				// The closing pair of a block waits until the output register is free.
				if (!(status.last_pair && status.out_busy)) begin
					cmd.op  = OP_SUM;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: sv/wcd_datapath.sv
// Datapath of the weighted color distance block: differences, shared multiplier,
// accumulator and output register. Depends on wcd_pkg.
`timescale 1ns / 1ps

module wcd_datapath
	import wcd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  wcd_cmd_t         cmd,
	output wcd_status_t      status,
	input  logic [CH_W-1:0]  a_red,
	input  logic [CH_W-1:0]  a_green,
	input  logic [CH_W-1:0]  a_blue,
	input  logic [CH_W-1:0]  b_red,
	input  logic [CH_W-1:0]  b_green,
	input  logic [CH_W-1:0]  b_blue,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OUT_W-1:0] block_distance
);

	logic [CH_W-1:0]     ar_q, ag_q, ab_q, br_q, bg_q, bb_q;
	logic [CH_W-1:0]     dr_q, dg_q, db_q;
	logic [SUMRED_W-1:0] s_q;
	logic [PROD_W-1:0]   prod_q;
	logic [SQ_W-1:0]     dr2_q, dg2_q, db2_q;
	logic [NUM_W-1:0]    num_q;
	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                out_valid_q;
	logic [OUT_W-1:0]    out_data_q;

	logic [OPA_W-1:0]    op_a;
	logic [SQ_W-1:0]     op_b;
	logic [PROD_W-1:0]   prod_d;
	logic [PAIR_W-1:0]   pair_d;
	logic [SUM_W-1:0]    sum_d;
	logic [OPA_W-1:0]    s_ext;

	assign s_ext = OPA_W'(s_q);

	// Operand selection for the one shared multiplier.
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (cmd.op)
			OP_SQR: begin
				op_a = OPA_W'(dr_q);
				op_b = SQ_W'(dr_q);
			end
			OP_SQG: begin
				op_a = OPA_W'(dg_q);
				op_b = SQ_W'(dg_q);
			end
			OP_SQB: begin
				op_a = OPA_W'(db_q);
				op_b = SQ_W'(db_q);
			end
			OP_WR: begin
				op_a = RED_BIAS + s_ext;
				op_b = dr2_q;
			end
			OP_WB: begin
				op_a = BLUE_BIAS - s_ext;
				op_b = db2_q;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign prod_d = {{(PROD_W-OPA_W){1'b0}}, op_a} * {{(PROD_W-SQ_W){1'b0}}, op_b};
	assign pair_d = num_q[NUM_W-1:FRAC_SHIFT];
	assign sum_d  = sum_q + SUM_W'(pair_d);

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				ar_q <= a_red;
				ag_q <= a_green;
				ab_q <= a_blue;
				br_q <= b_red;
				bg_q <= b_green;
				bb_q <= b_blue;
			end
			OP_DIFF: begin
				dr_q <= (ar_q > br_q) ? (ar_q - br_q) : (br_q - ar_q);
				dg_q <= (ag_q > bg_q) ? (ag_q - bg_q) : (bg_q - ag_q);
				db_q <= (ab_q > bb_q) ? (ab_q - bb_q) : (bb_q - ab_q);
				s_q  <= SUMRED_W'(ar_q) + SUMRED_W'(br_q);
			end
			OP_SQR: begin
				prod_q <= prod_d;
			end
			OP_SQG: begin
				dr2_q  <= prod_q[SQ_W-1:0];
				prod_q <= prod_d;
			end
			OP_SQB: begin
				dg2_q  <= prod_q[SQ_W-1:0];
				prod_q <= prod_d;
			end
			OP_WR: begin
				db2_q  <= prod_q[SQ_W-1:0];
				prod_q <= prod_d;
			end
			OP_WB: begin
				num_q  <= NUM_W'(prod_q) +
					{{(NUM_W-SQ_W-GREEN_SHIFT){1'b0}}, dg2_q, {GREEN_SHIFT{1'b0}}};
				prod_q <= prod_d;
			end
			OP_ACC: begin
				num_q <= num_q + NUM_W'(prod_q);
			end
			OP_SUM: begin
				if (cnt_q == LAST_CNT) begin
					out_data_q <= sum_d[SUM_W-1:AVG_SHIFT];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_SUM && cnt_q == LAST_CNT) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.op == OP_SUM) begin
				if (cnt_q == LAST_CNT) begin
					sum_q <= '0;
					cnt_q <= '0;
				end else begin
					sum_q <= sum_d;
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	assign status.last_pair = (cnt_q == LAST_CNT);
	assign status.out_busy  = out_valid_q && !out_ready;
	assign out_valid        = out_valid_q;
	assign block_distance   = out_data_q;

endmodule

FILE: sv/wcd_checker.sv
// Port-level checks of the weighted color distance block, bound to its top level.
// Depends on wcd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "block_weighted_color_distance_macros.svh"

module wcd_checker
	import wcd_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [OUT_W-1:0] block_distance
);

	// A pending result stays offered until it is taken.
	`WCD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

	// Only one pair is in flight: an input transfer closes the input side.
	`WCD_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

	// A new result appears only from the final step of a pair, never while idle.
	`WCD_ASSERT_IMPL(a_result_from_work, $rose(out_valid), !$past(in_ready))

	// The block average of the weighted distance never exceeds 9 * 2^32.
	`WCD_ASSERT_IMPL(a_out_range, out_valid, block_distance <= OUT_MAX)

endmodule

bind block_weighted_color_distance wcd_checker u_wcd_checker (.*);

FILE: test/block_weighted_color_distance_test.sv
// Self-checking testbench for block_weighted_color_distance: streams color pairs and checks the
// sixteen-pair block averages against a predictor kept inside the bench.
// Depends on wcd_pkg and the block_weighted_color_distance RTL.
`timescale 1ns / 1ps

module block_weighted_color_distance_test;
	import wcd_pkg::*;

	// One color pair as the driver presents it. The hold flag makes the driver wait
	// before this pair until every block average already owed has come out.
	typedef struct packed {
		logic [CH_W-1:0] a_red;
		logic [CH_W-1:0] a_green;
		logic [CH_W-1:0] a_blue;
		logic [CH_W-1:0] b_red;
		logic [CH_W-1:0] b_green;
		logic [CH_W-1:0] b_blue;
		logic            hold_for_drain;
	} color_pair_t;

	localparam logic [CH_W-1:0] CH_MAX       = '1;
	localparam int              RANDOM_BLOCKS = 31;
	localparam int              MAX_BLOCK     = 10;
	// Two block boundaries at which the sender stops until the output side is empty.
	localparam int              DRAIN_ITEM_1  = 160;
	localparam int              DRAIN_ITEM_2  = 400;
	// Transfers in this window run with both sides idle-free.
	localparam int              QUIET_FIRST   = 200;
	localparam int              QUIET_LAST    = 300;
	localparam int              IDLE_PERCENT  = 36;
	localparam int              TAIL_CYCLES   = 40;
	localparam int              CYCLE_LIMIT   = 200000;
	localparam int              SHOWN_ERRORS  = 10;

	logic             clk            = 1'b0;
	logic             arst_n         = 1'b0;
	logic             in_valid       = 1'b0;
	logic             in_ready;
	logic [CH_W-1:0]  a_red          = '0;
	logic [CH_W-1:0]  a_green        = '0;
	logic [CH_W-1:0]  a_blue         = '0;
	logic [CH_W-1:0]  b_red          = '0;
	logic [CH_W-1:0]  b_green        = '0;
	logic [CH_W-1:0]  b_blue         = '0;
	logic             out_valid;
	logic             out_ready      = 1'b0;
	logic [OUT_W-1:0] block_distance;

	block_weighted_color_distance dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.a_red          (a_red),
		.a_green        (a_green),
		.a_blue         (a_blue),
		.b_red          (b_red),
		.b_green        (b_green),
		.b_blue         (b_blue),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.block_distance (block_distance)
	);

	// Pairs still to be sent, the pair now on the bus, and the block averages owed.
	color_pair_t      pending_pairs[$];
	color_pair_t      pair_on_bus;
	logic [OUT_W-1:0] owed_averages[$];

	// Predictor state: running sum of scaled pair distances and pairs in this block.
	logic [SUM_W-1:0] running_sum = '0;
	logic [CNT_W-1:0] pairs_in_block = '0;

	int               pairs_sent = 0;
	int               error_count = 0;
	int               cycle_count = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Pair distance: the numerator shifted right by 17 and truncated. With 2^17 weights the red term is
	// (2^18 + sum of reds), green is 2^19 and blue is (3 * 2^17 - sum of reds); the
	// numerator stays below 2^54, so 64 bits hold it without loss.
	function automatic logic [63:0] weighted_pair_distance(input color_pair_t p);
		logic [16:0]     red_sum;
		logic [CH_W-1:0] d_red;
		logic [CH_W-1:0] d_green;
		logic [CH_W-1:0] d_blue;
		logic [63:0]     numerator;
		red_sum   = 17'(p.a_red) + 17'(p.b_red);
		d_red     = (p.a_red > p.b_red) ? p.a_red - p.b_red : p.b_red - p.a_red;
		d_green   = (p.a_green > p.b_green) ? p.a_green - p.b_green : p.b_green - p.a_green;
		d_blue    = (p.a_blue > p.b_blue) ? p.a_blue - p.b_blue : p.b_blue - p.a_blue;
		numerator = (64'd262144 + 64'(red_sum)) * (64'(d_red) * 64'(d_red))
		          + 64'd524288 * (64'(d_green) * 64'(d_green))
		          + (64'd393216 - 64'(red_sum)) * (64'(d_blue) * 64'(d_blue));
		return numerator >> 17;
	endfunction

	// Folds one accepted pair into the predicted block. The sixteenth pair of a block
	// owes one average, the sum shifted right by four, and clears the block.
	function automatic void accumulate_pair(input color_pair_t p);
		running_sum = running_sum + SUM_W'(weighted_pair_distance(p));
		if (pairs_in_block == CNT_W'(BLOCK_PAIRS - 1)) begin
			owed_averages.push_back(OUT_W'(running_sum >> AVG_SHIFT));
			running_sum    = '0;
			pairs_in_block = '0;
		end else begin
			pairs_in_block = pairs_in_block + 1'b1;
		end
	endfunction

	// Both sides idle at random, except while the transfer count is in the quiet window.
	function automatic bit idle_this_cycle();
		if (pairs_sent >= QUIET_FIRST && pairs_sent < QUIET_LAST)
			return 1'b0;
		return $urandom_range(99) < IDLE_PERCENT;
	endfunction

	function automatic color_pair_t make_pair(input logic [CH_W-1:0] ar, input logic [CH_W-1:0] ag,
			input logic [CH_W-1:0] ab, input logic [CH_W-1:0] br, input logic [CH_W-1:0] bg,
			input logic [CH_W-1:0] bb);
		color_pair_t p;
		p.a_red          = ar;
		p.a_green        = ag;
		p.a_blue         = ab;
		p.b_red          = br;
		p.b_green        = bg;
		p.b_blue         = bb;
		p.hold_for_drain = 1'b0;
		return p;
	endfunction

	// A channel value a small step away from base, clipped to the channel range.
	function automatic logic [CH_W-1:0] nearby_value(input logic [CH_W-1:0] base);
		int step;
		int v;
		step = $urandom_range(255);
		v    = $urandom_range(1) ? int'(base) + step : int'(base) - step;
		if (v < 0)
			v = 0;
		if (v > int'(CH_MAX))
			v = int'(CH_MAX);
		return CH_W'(v);
	endfunction

	function automatic logic [CH_W-1:0] extreme_value();
		return $urandom_range(1) ? CH_MAX : '0;
	endfunction

	function automatic void report_mismatch(input logic [OUT_W-1:0] want, input bit have_want);
		error_count++;
		if (error_count <= SHOWN_ERRORS) begin
			if (have_want)
				$display("block_distance mismatch: expected %0d, got %0d", want, block_distance);
			else
				$display("block_distance %0d came with no block average owed", block_distance);
		end
	endfunction

	// Driver: on a transfer the accepted pair goes to the predictor. A new pair is
	// presented only when the bus is free, so valid and payload stay steady while
	// the block stalls. A pair flagged for drain waits until no average is owed.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				accumulate_pair(pair_on_bus);
				pairs_sent++;
			end
			if (!(in_valid && !in_ready)) begin
				if (pending_pairs.size() != 0 && !idle_this_cycle() &&
						!(pending_pairs[0].hold_for_drain && owed_averages.size() != 0)) begin
					pair_on_bus = pending_pairs.pop_front();
					in_valid <= 1'b1;
					a_red    <= pair_on_bus.a_red;
					a_green  <= pair_on_bus.a_green;
					a_blue   <= pair_on_bus.a_blue;
					b_red    <= pair_on_bus.b_red;
					b_green  <= pair_on_bus.b_green;
					b_blue   <= pair_on_bus.b_blue;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: every output transfer is compared with the oldest owed average.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (owed_averages.size() == 0)
					report_mismatch('0, 1'b0);
				else if (block_distance !== owed_averages[0])
					report_mismatch(owed_averages.pop_front(), 1'b1);
				else
					void'(owed_averages.pop_front());
			end
			out_ready <= !idle_this_cycle();
		end
	end

	// Watchdog for a hung handshake.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		color_pair_t p;
		int          kind;
		int          total_pairs;

		// Directed block: channel extremes, each channel alone, both red-weight
		// ends of the blue term, equal colors, one-step differences, bit patterns.
		pending_pairs.push_back(make_pair('0, '0, '0, '0, '0, '0));
		pending_pairs.push_back(make_pair(CH_MAX, CH_MAX, CH_MAX, '0, '0, '0));
		pending_pairs.push_back(make_pair('0, '0, '0, CH_MAX, CH_MAX, CH_MAX));
		pending_pairs.push_back(make_pair('0, 16'h1234, 16'h4321, CH_MAX, 16'h1234, 16'h4321));
		pending_pairs.push_back(make_pair(CH_MAX, CH_MAX, CH_MAX, '0, CH_MAX, CH_MAX));
		pending_pairs.push_back(make_pair(16'h8000, '0, 16'h0F0F, 16'h8000, CH_MAX, 16'h0F0F));
		pending_pairs.push_back(make_pair('0, 16'h7777, '0, '0, 16'h7777, CH_MAX));
		pending_pairs.push_back(make_pair(CH_MAX, 16'h3333, CH_MAX, CH_MAX, 16'h3333, '0));
		pending_pairs.push_back(make_pair(16'h1357, 16'h2468, 16'hFEDC, 16'h1357, 16'h2468,
			16'hFEDC));
		pending_pairs.push_back(make_pair(CH_MAX, CH_MAX, CH_MAX, CH_MAX, CH_MAX, CH_MAX));
		pending_pairs.push_back(make_pair(16'h4000, 16'h0001, 16'hFFFE, 16'h4001, '0, CH_MAX));
		pending_pairs.push_back(make_pair('0, 16'h5A5A, '0, CH_MAX, 16'h5A5A, CH_MAX));
		pending_pairs.push_back(make_pair(16'hAAAA, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555,
			16'h5555));
		pending_pairs.push_back(make_pair(16'h5555, 16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA,
			16'hAAAA));
		pending_pairs.push_back(make_pair(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
			16'h7FFF));
		pending_pairs.push_back(make_pair(CH_MAX, 16'h0BAD, CH_MAX, '0, 16'h0BAD, '0));

		// Random blocks. One block is all full-scale differences, which drives the
		// average toward its largest value; the rest mix equal colors, extremes,
		// close colors and fully random pairs.
		for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
			for (int i = 0; i < BLOCK_PAIRS; i++) begin
				kind = $urandom_range(9);
				if (blk == MAX_BLOCK) begin
					if ($urandom_range(1))
						p = make_pair('0, '0, '0, CH_MAX, CH_MAX, CH_MAX);
					else
						p = make_pair(CH_MAX, CH_MAX, CH_MAX, '0, '0, '0);
				end else if (kind == 0) begin
					p = make_pair(CH_W'($urandom), CH_W'($urandom), CH_W'($urandom), '0, '0, '0);
					p.b_red   = p.a_red;
					p.b_green = p.a_green;
					p.b_blue  = p.a_blue;
				end else if (kind == 1) begin
					p = make_pair(extreme_value(), extreme_value(), extreme_value(),
						extreme_value(), extreme_value(), extreme_value());
				end else if (kind == 2) begin
					p = make_pair(CH_W'($urandom), CH_W'($urandom), CH_W'($urandom), '0, '0, '0);
					p.b_red   = nearby_value(p.a_red);
					p.b_green = nearby_value(p.a_green);
					p.b_blue  = nearby_value(p.a_blue);
				end else begin
					p = make_pair(CH_W'($urandom), CH_W'($urandom), CH_W'($urandom),
						CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
				end
				p.hold_for_drain = (pending_pairs.size() == DRAIN_ITEM_1) ||
					(pending_pairs.size() == DRAIN_ITEM_2);
				pending_pairs.push_back(p);
			end
		end
		total_pairs = pending_pairs.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every pair to be taken and every average to come out, then let
		// the block run on for a while to catch any stray result.
		while (pairs_sent < total_pairs || owed_averages.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0 && owed_averages.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
